// File: sv/epoch_bin_pair_averager_assert.svh
// Assertion macros shared by the epoch bin pair averager modules.
`ifndef EPOCH_BIN_PAIR_AVERAGER_ASSERT_SVH
`define EPOCH_BIN_PAIR_AVERAGER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define EBPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define EBPA_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define EBPA_ASSERT(lbl, prop, msg)
`define EBPA_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// File: sv/ebpa_pkg.sv
// Package with the widths, codes and types of the epoch bin pair averager.
`timescale 1ns / 1ps
package ebpa_pkg;
  localparam int EPOCH_W         = 22;
  localparam int VAL_W           = 24;
  localparam int MAX_PER_BIN     = 1024;
  localparam int CNT_W           = $clog2(MAX_PER_BIN + 1);
  localparam int SUM_W           = VAL_W + $clog2(MAX_PER_BIN);
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = EPOCH_W;
  localparam int BIN_WIDTH_RESET = 2048;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
  localparam int STEP_W          = $clog2(SUM_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIN_WIDTH = CFG_IDX_W'(0),
    CFG_DROP_NEG  = CFG_IDX_W'(1)
  } ebpa_cfg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } ebpa_back_e;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [CNT_W-1:0]        count;
  } ebpa_job_t;

  typedef struct packed {
    logic      push;
    ebpa_job_t job;
  } ebpa_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ebpa_qstat_t;
endpackage

// File: sv/ebpa_in_if.sv
// Input channel carrying one timestamped measurement pair per request.
`timescale 1ns / 1ps
interface ebpa_in_if;
  import ebpa_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [EPOCH_W-1:0]      epoch_value;
  logic signed [VAL_W-1:0] x_value;
  logic signed [VAL_W-1:0] y_value;
  modport source (output valid, epoch_value, x_value, y_value, input ready);
  modport sink (input valid, epoch_value, x_value, y_value, output ready);
endinterface

// File: sv/ebpa_out_if.sv
// Output channel carrying the two means of one closed bin per request.
`timescale 1ns / 1ps
interface ebpa_out_if;
  import ebpa_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] mean_x;
  logic signed [VAL_W-1:0] mean_y;
  modport source (output valid, mean_x, mean_y, input ready);
  modport sink (input valid, mean_x, mean_y, output ready);
endinterface

// File: sv/ebpa_cfg_if.sv
// Configuration write channel with register index and write data.
`timescale 1ns / 1ps
interface ebpa_cfg_if;
  import ebpa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/ebpa_front.sv
// Front end: configuration registers, bin close test and running sums.
`timescale 1ns / 1ps
`include "epoch_bin_pair_averager_assert.svh"
module ebpa_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ebpa_in_if.sink              in_i,
  ebpa_cfg_if.sink             cfg_i,
  input  ebpa_pkg::ebpa_qstat_t qstat_i,
  output ebpa_pkg::ebpa_push_t  push_o
);
  import ebpa_pkg::*;

  logic [EPOCH_W-1:0]      bin_width_q, bin_width_d;
  logic                    drop_neg_q, drop_neg_d;
  logic [EPOCH_W-1:0]      bin_start_q, bin_start_d;
  logic signed [SUM_W-1:0] sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [CNT_W-1:0]        count_q, count_d;

  logic                    accept;
  logic [EPOCH_W:0]        bin_end;
  logic                    close;
  logic signed [SUM_W-1:0] base_x, base_y, ext_x, ext_y;
  logic [CNT_W-1:0]        base_count;
  logic                    take;

  assign in_i.ready  = !qstat_i.full;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && !qstat_i.full;

  assign bin_end = {1'b0, bin_start_q} + {1'b0, bin_width_q};
  assign close   = {1'b0, in_i.epoch_value} > bin_end;

  assign ext_x = {{(SUM_W - VAL_W){in_i.x_value[VAL_W-1]}}, in_i.x_value};
  assign ext_y = {{(SUM_W - VAL_W){in_i.y_value[VAL_W-1]}}, in_i.y_value};

  always_comb begin
    base_x     = close ? '0 : sum_x_q;
    base_y     = close ? '0 : sum_y_q;
    base_count = close ? '0 : count_q;
    take = !(drop_neg_q && (in_i.x_value[VAL_W-1] || in_i.y_value[VAL_W-1])) &&
           (base_count < CNT_W'(MAX_PER_BIN));
  end

  always_comb begin
    bin_start_d = bin_start_q;
    sum_x_d     = sum_x_q;
    sum_y_d     = sum_y_q;
    count_d     = count_q;
    if (accept) begin
      bin_start_d = close ? in_i.epoch_value : bin_start_q;
      sum_x_d     = take ? base_x + ext_x : base_x;
      sum_y_d     = take ? base_y + ext_y : base_y;
      count_d     = take ? base_count + CNT_W'(1) : base_count;
    end
  end

  always_comb begin
    bin_width_d = bin_width_q;
    drop_neg_d  = drop_neg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_BIN_WIDTH: bin_width_d = cfg_i.data[EPOCH_W-1:0];
        CFG_DROP_NEG:  drop_neg_d  = cfg_i.data[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    push_o.push      = accept && close && (count_q != '0);
    push_o.job.sum_x = sum_x_q;
    push_o.job.sum_y = sum_y_q;
    push_o.job.count = count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_width_q <= EPOCH_W'(BIN_WIDTH_RESET);
      drop_neg_q  <= 1'b0;
      bin_start_q <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      count_q     <= '0;
    end else begin
      bin_width_q <= bin_width_d;
      drop_neg_q  <= drop_neg_d;
      bin_start_q <= bin_start_d;
      sum_x_q     <= sum_x_d;
      sum_y_q     <= sum_y_d;
      count_q     <= count_d;
    end
  end

  `EBPA_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_PER_BIN), "Sample count above limit.")
  `EBPA_ASSERT(a_restart, accept && close |=> bin_start_q == $past(in_i.epoch_value), "Bin did not restart.")
endmodule

// File: sv/ebpa_fifo.sv
// Short queue of closed-bin sums between the front end and the divider.
`timescale 1ns / 1ps
`include "epoch_bin_pair_averager_assert.svh"
module ebpa_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ebpa_pkg::ebpa_push_t  push_i,
  input  logic                  pop_i,
  output ebpa_pkg::ebpa_qstat_t qstat_o,
  output ebpa_pkg::ebpa_job_t   head_o
);
  import ebpa_pkg::*;

  ebpa_job_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] ptr);
    ptr_next = (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + QPTR_W'(1);
  endfunction

  always_comb begin
    qstat_o.full  = cnt_q == QCNT_W'(QUEUE_DEPTH);
    qstat_o.empty = cnt_q == '0;
    head_o        = mem_q[rd_ptr_q];
    wr_ptr_d      = push_i.push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d      = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d         = cnt_q;
    if (push_i.push && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i.push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `EBPA_ASSERT_NEVER(a_no_overflow, push_i.push && qstat_o.full, "Push into a full queue.")
  `EBPA_ASSERT_NEVER(a_no_underflow, pop_i && qstat_o.empty, "Pop from an empty queue.")
endmodule

// File: sv/ebpa_back.sv
// Back end: serial restoring divider for both means and the output register.
`timescale 1ns / 1ps
`include "epoch_bin_pair_averager_assert.svh"
module ebpa_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ebpa_pkg::ebpa_qstat_t qstat_i,
  input  ebpa_pkg::ebpa_job_t   head_i,
  output logic                  pop_o,
  ebpa_out_if.source            out_o
);
  import ebpa_pkg::*;

  ebpa_back_e              state_q, state_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic [CNT_W-1:0]        div_q, div_d;
  logic [CNT_W-1:0]        rem_x_q, rem_x_d, rem_y_q, rem_y_d;
  logic [SUM_W-1:0]        quo_x_q, quo_x_d, quo_y_q, quo_y_d;
  logic                    neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic signed [VAL_W-1:0] mean_x_q, mean_x_d, mean_y_q, mean_y_d;

  logic [CNT_W:0]          part_x, part_y, sub_x, sub_y;
  logic                    ge_x, ge_y;
  logic [SUM_W-1:0]        res_x, res_y;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (!qstat_i.empty) state_d = BK_DIV;
      BK_DIV:  if (step_q == '0) state_d = BK_HOLD;
      BK_HOLD: if (out_o.ready) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    out_o.valid = 1'b0;
    case (state_q)
      BK_IDLE: pop_o = !qstat_i.empty;
      BK_HOLD: out_o.valid = 1'b1;
      default: ;
    endcase
  end

  assign out_o.mean_x = mean_x_q;
  assign out_o.mean_y = mean_y_q;

  always_comb begin
    part_x  = {rem_x_q, quo_x_q[SUM_W-1]};
    part_y  = {rem_y_q, quo_y_q[SUM_W-1]};
    sub_x   = part_x - {1'b0, div_q};
    sub_y   = part_y - {1'b0, div_q};
    ge_x    = part_x >= {1'b0, div_q};
    ge_y    = part_y >= {1'b0, div_q};
    step_d  = step_q;
    div_d   = div_q;
    rem_x_d = rem_x_q;
    rem_y_d = rem_y_q;
    quo_x_d = quo_x_q;
    quo_y_d = quo_y_q;
    neg_x_d = neg_x_q;
    neg_y_d = neg_y_q;
    mean_x_d = mean_x_q;
    mean_y_d = mean_y_q;
    res_x   = '0;
    res_y   = '0;
    if (pop_o) begin
      step_d  = STEP_W'(SUM_W - 1);
      div_d   = head_i.count;
      rem_x_d = '0;
      rem_y_d = '0;
      neg_x_d = head_i.sum_x[SUM_W-1];
      neg_y_d = head_i.sum_y[SUM_W-1];
      quo_x_d = head_i.sum_x[SUM_W-1] ? ~head_i.sum_x + SUM_W'(1) : head_i.sum_x;
      quo_y_d = head_i.sum_y[SUM_W-1] ? ~head_i.sum_y + SUM_W'(1) : head_i.sum_y;
    end else if (state_q == BK_DIV) begin
      step_d  = step_q - STEP_W'(1);
      rem_x_d = ge_x ? sub_x[CNT_W-1:0] : part_x[CNT_W-1:0];
      rem_y_d = ge_y ? sub_y[CNT_W-1:0] : part_y[CNT_W-1:0];
      quo_x_d = {quo_x_q[SUM_W-2:0], ge_x};
      quo_y_d = {quo_y_q[SUM_W-2:0], ge_y};
      if (step_q == '0) begin
        res_x    = neg_x_q ? ~quo_x_d + SUM_W'(1) : quo_x_d;
        res_y    = neg_y_q ? ~quo_y_d + SUM_W'(1) : quo_y_d;
        mean_x_d = res_x[VAL_W-1:0];
        mean_y_d = res_y[VAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    div_q    <= div_d;
    rem_x_q  <= rem_x_d;
    rem_y_q  <= rem_y_d;
    quo_x_q  <= quo_x_d;
    quo_y_q  <= quo_y_d;
    neg_x_q  <= neg_x_d;
    neg_y_q  <= neg_y_d;
    mean_x_q <= mean_x_d;
    mean_y_q <= mean_y_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  `EBPA_ASSERT(a_div_nonzero, state_q == BK_DIV |-> div_q != '0, "Division by a zero count.")
  `EBPA_ASSERT(a_div_done, state_q == BK_DIV && step_q == '0 |=> state_q == BK_HOLD, "Divider did not finish.")
endmodule

// File: sv/epoch_bin_pair_averager.sv
// Top level of the two-channel time-binned averager.
`timescale 1ns / 1ps
// The block takes one measurement pair per clock cycle while its two-entry
// queue of closed bins has room. A pair whose epoch lies beyond the open bin
// closes that bin; if the bin held samples, its sums go to the queue. The back
// end pops the oldest sums when idle, runs the 34-step restoring divider that
// forms both quotients side by side, and then holds a request with both means
// until the output is ready. Bins may close while the divider works on an
// earlier bin; the input stalls only when two closed bins already wait.
// The last open bin is never reported.
// Configuration writes are taken in any cycle and should be made while idle.
module epoch_bin_pair_averager (
  input  logic       clk_i,
  input  logic       rst_ni,
  ebpa_in_if.sink    in_i,
  ebpa_out_if.source out_o,
  ebpa_cfg_if.sink   cfg_i
);
  import ebpa_pkg::*;

  ebpa_push_t  push;
  ebpa_qstat_t qstat;
  ebpa_job_t   head;
  logic        pop;

  ebpa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cfg_i   (cfg_i),
    .qstat_i (qstat),
    .push_o  (push)
  );

  ebpa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .qstat_o (qstat),
    .head_o  (head)
  );

  ebpa_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qstat_i (qstat),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );
endmodule

// File: dv/testbench.sv
// Self-checking testbench for the two-channel time-binned pair averager.
`timescale 1ns / 1ps
module testbench;
  import ebpa_pkg::*;

  localparam longint EPOCH_MAX = (64'd1 << EPOCH_W) - 1;
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam int DIV_SETTLE = 100;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [VAL_W-1:0]   x;
    logic [VAL_W-1:0]   y;
  } pair_t;

  typedef struct packed {
    logic [VAL_W-1:0] mean_x;
    logic [VAL_W-1:0] mean_y;
  } means_t;

  logic clk_i;
  logic rst_ni;

  ebpa_in_if  in_bus ();
  ebpa_out_if out_bus ();
  ebpa_cfg_if cfg_bus ();

  epoch_bin_pair_averager dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  pair_t  pending_pairs[$];
  means_t bin_mean_q[$];

  logic [EPOCH_W-1:0]      bin_start    = '0;
  logic signed [SUM_W-1:0] sum_x        = '0;
  logic signed [SUM_W-1:0] sum_y        = '0;
  logic [CNT_W-1:0]        sample_count = '0;
  logic [EPOCH_W-1:0]      bin_width    = EPOCH_W'(BIN_WIDTH_RESET);
  logic                    drop_neg     = 1'b0;

  longint gen_start  = 0;
  longint gen_width  = BIN_WIDTH_RESET;
  longint last_epoch = 0;

  logic in_taken  = 1'b0;
  logic cfg_taken = 1'b0;
  int   in_gap    = 0;
  int   out_hold  = 0;
  bit   in_calm   = 1'b0;
  bit   out_calm  = 1'b0;
  int   in_tick   = 0;
  int   out_tick  = 0;

  int pairs_fed     = 0;
  int means_checked = 0;
  int reg_writes    = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return VAL_W'($urandom_range(0, 8)) - VAL_W'(4);
      default: return VAL_W'($urandom());
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    mismatches++;
    if (mismatches <= 50) begin
      $display("%0t: %s: got %0d, expected %0d", $time, what, $signed(got), $signed(want));
    end
  endtask

  // Closes the open bin when the epoch passes its end, then folds the sample in.
  task automatic fold_pair(input pair_t p);
    logic [EPOCH_W:0] bin_end;
    longint sx;
    longint sy;
    longint n;
    means_t m;
    bin_end = {1'b0, bin_start} + {1'b0, bin_width};
    if ({1'b0, p.epoch} > bin_end) begin
      if (sample_count != '0) begin
        sx = sum_x;
        sy = sum_y;
        n = sample_count;
        m.mean_x = VAL_W'(sx / n);
        m.mean_y = VAL_W'(sy / n);
        bin_mean_q.push_back(m);
      end
      sum_x = '0;
      sum_y = '0;
      sample_count = '0;
      bin_start = p.epoch;
    end
    if (!(drop_neg && (p.x[VAL_W-1] || p.y[VAL_W-1])) && sample_count < MAX_PER_BIN) begin
      sum_x = sum_x + $signed(p.x);
      sum_y = sum_y + $signed(p.y);
      sample_count = sample_count + 1'b1;
    end
  endtask

  always @(posedge clk_i) begin
    means_t m;
    if (rst_ni) begin
      in_taken <= in_bus.valid && in_bus.ready;
      cfg_taken <= cfg_bus.valid && cfg_bus.ready;
      if (in_bus.valid && in_bus.ready) begin
        fold_pair('{in_bus.epoch_value, in_bus.x_value, in_bus.y_value});
        pairs_fed++;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (bin_mean_q.size() == 0) begin
          report_mismatch("mean_x of a request with no closed bin pending",
                          out_bus.mean_x, '0);
        end else begin
          m = bin_mean_q.pop_front();
          if (out_bus.mean_x !== m.mean_x) report_mismatch("mean_x", out_bus.mean_x, m.mean_x);
          if (out_bus.mean_y !== m.mean_y) report_mismatch("mean_y", out_bus.mean_y, m.mean_y);
          means_checked++;
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (ebpa_cfg_e'(cfg_bus.index))
          CFG_BIN_WIDTH: bin_width = cfg_bus.data[EPOCH_W-1:0];
          CFG_DROP_NEG:  drop_neg = cfg_bus.data[0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles == STALL_LIMIT) begin
        $display("Timeout: no request moved for %0d cycles.", STALL_LIMIT);
        $display("** epoch_bin_pair_averager: FAILED **");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    pair_t p;
    if (rst_ni) begin
      if (++in_tick % 300 == 0) in_calm = ($urandom_range(0, 2) == 0);
      if (in_bus.valid && !in_taken) begin
      end else if (in_gap > 0) begin
        in_gap--;
        in_bus.valid <= 1'b0;
      end else if (pending_pairs.size() != 0) begin
        p = pending_pairs.pop_front();
        in_bus.valid <= 1'b1;
        in_bus.epoch_value <= p.epoch;
        in_bus.x_value <= p.x;
        in_bus.y_value <= p.y;
        in_gap = in_calm ? 0 : idle_len();
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (++out_tick % 300 == 0) out_calm = ($urandom_range(0, 2) == 0);
      if (out_hold > 0) begin
        out_hold--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        if (!out_calm && $urandom_range(0, 99) < 20) out_hold = idle_len();
      end
    end
  end

  // Queues one pair and tracks where the block's open bin will start.
  task automatic add_pair(input longint e, input logic [VAL_W-1:0] x,
                          input logic [VAL_W-1:0] y);
    if (e > EPOCH_MAX) e = EPOCH_MAX;
    pending_pairs.push_back('{EPOCH_W'(e), x, y});
    if (e > gen_start + gen_width) gen_start = e;
    if (e >= last_epoch) last_epoch = e;
  endtask

  task automatic random_pairs(input int n);
    int unsigned r;
    longint lim;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      lim = gen_start + gen_width;
      if (r < 25 && lim < EPOCH_MAX) begin
        add_pair(lim + 1 + $urandom_range(0, 3), rand_value(), rand_value());
      end else if (r < 30) begin
        add_pair($urandom_range(0, int'(last_epoch)), rand_value(), rand_value());
      end else begin
        add_pair(last_epoch + $urandom_range(0, int'(gen_width / 8) + 1),
                 rand_value(), rand_value());
      end
    end
  endtask

  // The queue, the bus and the expected means are read at the rising edge,
  // where the driver's values have settled.
  task automatic drain();
    do @(posedge clk_i);
    while (pending_pairs.size() != 0 || in_bus.valid || bin_mean_q.size() != 0);
    repeat (DIV_SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input ebpa_cfg_e idx, input longint val);
    drain();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= CFG_DATA_W'(val);
    do @(negedge clk_i); while (!cfg_taken);
    cfg_bus.valid <= 1'b0;
    if (idx == CFG_BIN_WIDTH) gen_width = val;
    reg_writes++;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.epoch_value = '0;
    in_bus.x_value = '0;
    in_bus.y_value = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_BIN_WIDTH;
    cfg_bus.data = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: extremes, a sample on the bin end, a decreasing epoch,
    // and a negative mean that must truncate toward zero.
    add_pair(0, VAL_MAX, VAL_MAX);
    add_pair(0, VAL_MIN, VAL_MIN);
    add_pair(100, 0, 0);
    add_pair(100, -1, 1);
    add_pair(2048, 1, -1);
    add_pair(2049, 5, 5);
    add_pair(10, -3, 7);
    add_pair(6000, -7, 0);
    add_pair(6000, 0, 0);
    add_pair(8100, 3, -3);
    add_pair(12000, VAL_MAX, VAL_MIN);

    // Zero width with negatives dropped; the bin opened at 12001 stays empty.
    write_reg(CFG_BIN_WIDTH, 0);
    write_reg(CFG_DROP_NEG, 1);
    add_pair(12000, -1, 5);
    add_pair(12000, 5, -1);
    add_pair(12000, 2, 2);
    add_pair(12001, -4, -4);
    add_pair(12002, 1, 1);
    add_pair(12002, 0, 0);
    random_pairs(150);

    write_reg(CFG_BIN_WIDTH, 37);
    write_reg(CFG_DROP_NEG, 0);
    random_pairs(150);

    write_reg(CFG_BIN_WIDTH, 1);
    write_reg(CFG_DROP_NEG, 1);
    random_pairs(100);

    // One bin far past its sample limit, mostly at the value extremes.
    write_reg(CFG_BIN_WIDTH, 3000);
    write_reg(CFG_DROP_NEG, 0);
    add_pair(gen_start + gen_width + 1, VAL_MIN, VAL_MAX);
    for (int i = 0; i < MAX_PER_BIN + 16; i++) begin
      add_pair(gen_start + $urandom_range(0, 3000),
               ($urandom_range(0, 4) != 0) ? VAL_MIN : rand_value(),
               ($urandom_range(0, 4) != 0) ? VAL_MAX : rand_value());
    end
    random_pairs(40);

    write_reg(CFG_BIN_WIDTH, 100000);
    write_reg(CFG_DROP_NEG, 1);
    random_pairs(60);

    // The widest bin ends beyond the epoch range, so the top epoch never closes it.
    write_reg(CFG_BIN_WIDTH, EPOCH_MAX);
    write_reg(CFG_DROP_NEG, 0);
    for (int i = 0; i < 5; i++) add_pair(EPOCH_MAX, rand_value(), rand_value());

    drain();
    if (bin_mean_q.size() != 0) begin
      report_mismatch("closed bins never reported", VAL_W'(bin_mean_q.size()), '0);
    end
    $display("Fed %0d measurement pairs through %0d register writes, bin widths 0 to %0d.",
             pairs_fed, reg_writes, EPOCH_MAX);
    $display("Compared %0d closed-bin means, with %0d mismatches.", means_checked, mismatches);
    if (mismatches == 0) begin
      $display("** epoch_bin_pair_averager: PASSED **");
    end else begin
      $display("** epoch_bin_pair_averager: FAILED **");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+sv
sv/ebpa_pkg.sv
sv/ebpa_in_if.sv
sv/ebpa_out_if.sv
sv/ebpa_cfg_if.sv
sv/ebpa_front.sv
sv/ebpa_fifo.sv
sv/ebpa_back.sv
sv/epoch_bin_pair_averager.sv
dv/testbench.sv
